// File: rtl/ils_pkg.sv
`default_nettype none

package ils_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GET,
    S_RM_FIRST,
    S_RM_SHIFT
  } state_e;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned TotalWidth = 9;

  typedef struct packed {
    status_e                 status;
    logic [ValueWidth-1:0]   value;
    logic [TotalWidth-1:0]   total;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/ils_ram.sv
`default_nettype none

module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AddrWidth = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ils_ctrl.sv
`default_nettype none

module ils_ctrl #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AddrWidth = $clog2(CAPACITY)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [7:0]            position_i,
  input  wire logic [31:0]           item_value_i,
  input  wire logic                  out_free_i,
  output logic                       res_load_o,
  output ils_pkg::res_t              res_o,
  output logic                       mem_we_o,
  output logic [AddrWidth-1:0]       mem_waddr_o,
  output logic [DATA_WIDTH-1:0]      mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrWidth-1:0]       mem_raddr_o,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata_i
);

  import ils_pkg::*;

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
  localparam int unsigned CmpWidth = (CntWidth > 8) ? CntWidth : 8;
  localparam logic [CntWidth-1:0] CapC = CntWidth'(CAPACITY);

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [CntWidth-1:0]   ptr_q, ptr_d;
  logic [AddrWidth-1:0]  wr_q, wr_d;
  logic [DATA_WIDTH-1:0] removed_q, removed_d;

  opcode_e               op;
  logic                  accept;
  logic                  in_range;
  logic                  more;
  logic [DATA_WIDTH-1:0] word;
  logic [63:0]           rdata_wide;
  logic [63:0]           removed_wide;

  assign in_ready_o   = (state_q == S_IDLE) && out_free_i;
  assign accept       = in_valid_i && in_ready_o;
  assign op           = opcode_e'(opcode_i);
  assign in_range     = CmpWidth'(position_i) < CmpWidth'(count_q);
  assign more         = ptr_q < count_q;
  assign word         = DATA_WIDTH'(64'(item_value_i));
  assign rdata_wide   = 64'(mem_rdata_i);
  assign removed_wide = 64'(removed_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_range) begin
          if (op == OP_GET) begin
            state_d = S_GET;
          end else if (op == OP_REMOVE) begin
            state_d = S_RM_FIRST;
          end
        end
      end
      S_GET: begin
        state_d = S_IDLE;
      end
      S_RM_FIRST: begin
        state_d = more ? S_RM_SHIFT : S_IDLE;
      end
      S_RM_SHIFT: begin
        state_d = more ? S_RM_SHIFT : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we_o     = 1'b0;
    mem_waddr_o  = wr_q;
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = AddrWidth'(ptr_q);
    res_load_o   = 1'b0;
    res_o.status = ST_OK;
    res_o.value  = '0;
    count_d      = count_q;
    ptr_d        = ptr_q;
    wr_d         = wr_q;
    removed_d    = removed_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mem_raddr_o = AddrWidth'(position_i);
          ptr_d       = CntWidth'(position_i) + CntWidth'(1);
          wr_d        = AddrWidth'(position_i);
          unique case (op)
            OP_APPEND: begin
              res_load_o = 1'b1;
              if (count_q < CapC) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AddrWidth'(count_q);
                mem_wdata_o = word;
                count_d     = count_q + CntWidth'(1);
              end else begin
                res_o.status = ST_FULL;
              end
            end
            OP_GET, OP_REMOVE: begin
              if (in_range) begin
                mem_re_o = 1'b1;
              end else begin
                res_o.status = ST_BOUNDS;
                res_load_o   = 1'b1;
              end
            end
            default: begin
              res_load_o = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        res_o.value = rdata_wide[31:0];
        res_load_o  = 1'b1;
      end
      S_RM_FIRST: begin
        removed_d = mem_rdata_i;
        if (more) begin
          mem_re_o = 1'b1;
          ptr_d    = ptr_q + CntWidth'(1);
        end else begin
          count_d     = count_q - CntWidth'(1);
          res_o.value = rdata_wide[31:0];
          res_load_o  = 1'b1;
        end
      end
      S_RM_SHIFT: begin
        mem_we_o = 1'b1;
        wr_d     = wr_q + AddrWidth'(1);
        if (more) begin
          mem_re_o = 1'b1;
          ptr_d    = ptr_q + CntWidth'(1);
        end else begin
          count_d     = count_q - CntWidth'(1);
          res_o.value = removed_wide[31:0];
          res_load_o  = 1'b1;
        end
      end
      default: begin
        res_load_o = 1'b0;
      end
    endcase
    res_o.total = TotalWidth'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    wr_q      <= wr_d;
    removed_q <= removed_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count exceeds capacity");

  a_shift_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RM_SHIFT) |-> ((CntWidth'(wr_q) + CntWidth'(1)) < count_q))
    else $error("shift writes beyond the last entry");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> out_free_i)
    else $error("result loaded while the output register is held");

endmodule

`default_nettype wire

// File: rtl/indexed_list_store_top.sv
// Channel  Handshake                  Payload
// input    in_valid_i / in_ready_o    opcode_i, position_i, item_value_i
// output   out_valid_o / out_ready_i  status_o, read_value_o, entry_total_o
//
// Append, an out-of-bounds access and the unused opcode complete without a memory read.
// Get waits for the registered memory read before its result is loaded.
// Remove reads the entry at the index, then moves each later entry down by one,
// as the single memory read port and write port stream the shift.
// Reset clears the count, the state and the output valid flag; stored words are not cleared.
// A transaction is taken only when no operation is in progress and the output
// register is empty or being read in the same cycle.

`default_nettype none

module indexed_list_store_top #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [31:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      read_value_o,
  output logic [8:0]       entry_total_o
);

  import ils_pkg::*;

  localparam int unsigned AddrWidth = $clog2(CAPACITY);

  logic                  out_valid_q;
  res_t                  res_q;
  res_t                  res;
  logic                  res_load;
  logic                  out_free;
  logic                  mem_we;
  logic [AddrWidth-1:0]  mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AddrWidth-1:0]  mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  ils_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH),
    .AddrWidth (AddrWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ils_ram #(
    .WIDTH    (DATA_WIDTH),
    .DEPTH    (CAPACITY),
    .AddrWidth(AddrWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign read_value_o  = res_q.value;
  assign entry_total_o = res_q.total;

endmodule

`default_nettype wire
